// File: design/rx_fifo_xon_xoff_flow_control_macros.svh
// Assertion macros used by the receive FIFO top-level design file.
`ifndef RX_FIFO_XON_XOFF_FLOW_CONTROL_MACROS_SVH
`define RX_FIFO_XON_XOFF_FLOW_CONTROL_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define RXFC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rxfc invariant violated");

// When the trigger holds, the consequence must hold in the next cycle.
`define RXFC_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("rxfc next-cycle check failed");

`endif

// File: design/rxfc_pkg.sv
`timescale 1ns / 1ps
package rxfc_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int CNT_W      = 6;
  localparam int BYTE_W     = 8;

  localparam logic [CNT_W-1:0] XOFF_LEVEL_RST = CNT_W'(16);
  localparam logic [CNT_W-1:0] XON_LEVEL_RST  = CNT_W'(8);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_XOFF_LEVEL = 1'b0,
    REG_XON_LEVEL  = 1'b1
  } reg_index_t;

  typedef enum logic {
    FLOW_XON  = 1'b0,
    FLOW_XOFF = 1'b1
  } flow_code_t;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_in;
  } req_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              empty_flag;
    logic              overflow_flag;
    logic              flow_send;
    logic              flow_code;
    logic [CNT_W-1:0]  fill_level;
  } rsp_item_t;

  // Command broadcast to every storage cell.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] data;
  } cell_ctl_t;

endpackage

// File: design/rx_fifo_xon_xoff_flow_control.sv
`timescale 1ns / 1ps
// Receive byte FIFO with XON/XOFF flow control requests.
// The req channel carries one item per handshake: opcode 0 pushes data_in,
// opcode 1 pops the oldest byte. Every accepted item yields exactly one item
// on the rsp channel with the popped byte, status flags, an optional flow
// control request (XOFF when a push sees the count at or above the upper
// limit, XON when a pop drops it below the lower limit) and the new count.
// The user must write the limits on the cfg port only while no item is in
// flight; the block itself does not enforce this. Storage is a row of byte
// cells that shift toward the head on every pop; a push fills the first
// free cell behind the occupied ones. The result is registered at the edge
// that accepts the item. The block takes one item per cycle while rsp_ready
// stays high. When the receiver stalls, the held result blocks req_ready
// until it is taken. Synchronous reset empties the FIFO, returns to the XON
// state and loads the limit defaults 16 and 8; no clearing pass is needed.
module rx_fifo_xon_xoff_flow_control import rxfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_item_t        req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_item_t        rsp,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

`include "rx_fifo_xon_xoff_flow_control_macros.svh"

  logic                  accept;
  cell_ctl_t             cell_ctl;
  logic [CNT_W-1:0]      count;
  logic [FIFO_DEPTH-1:0] occ;
  logic [FIFO_DEPTH-1:0] occ_prev;
  logic [FIFO_DEPTH-1:0] occ_next;
  logic [BYTE_W-1:0]     cell_data [FIFO_DEPTH];
  logic [BYTE_W-1:0]     cell_next [FIFO_DEPTH];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign occ_prev = {occ[FIFO_DEPTH-2:0], 1'b1};
  assign occ_next = {1'b0, occ[FIFO_DEPTH-1:1]};

  genvar i;
  generate
    for (i = 0; i < FIFO_DEPTH; i++) begin : g_cell
      if (i == FIFO_DEPTH - 1) begin : g_last
        assign cell_next[i] = '0;
      end else begin : g_mid
        assign cell_next[i] = cell_data[i+1];
      end

      rxfc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (cell_ctl),
        .prev_occ  (occ_prev[i]),
        .next_occ  (occ_next[i]),
        .next_data (cell_next[i]),
        .occ       (occ[i]),
        .data      (cell_data[i])
      );
    end
  endgenerate

  rxfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .head_data (cell_data[0]),
    .rsp_ready (rsp_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_ctl  (cell_ctl),
    .count     (count),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // The occupied cells always form an unbroken run from the head.
  `RXFC_ASSERT_ALWAYS(a_occ_prefix, clk, rst, ((occ >> 1) & ~occ) == '0)
  `RXFC_ASSERT_ALWAYS(a_count_match, clk, rst, $countones(occ) == 32'(count))
  `RXFC_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(FIFO_DEPTH))
  `RXFC_ASSERT_NEXT(a_pop_level, clk, rst, accept && req.opcode == OP_POP && count != '0,
    rsp.data_valid && rsp.fill_level == $past(count) - CNT_W'(1))

endmodule

// File: design/rxfc_cell.sv
`timescale 1ns / 1ps
module rxfc_cell import rxfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic              prev_occ,
  input  logic              next_occ,
  input  logic [BYTE_W-1:0] next_data,
  output logic              occ,
  output logic [BYTE_W-1:0] data
);

  logic load;

  // The tail cell is the first free one behind an occupied neighbor, or the head cell when all are free.
  assign load = ctl.push && !occ && prev_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.pop) begin
      occ <= next_occ;
    end else if (load) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      data <= next_data;
    end else if (load) begin
      data <= ctl.data;
    end
  end

endmodule

// File: design/rxfc_ctrl.sv
`timescale 1ns / 1ps
module rxfc_ctrl import rxfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  req_item_t         req,
  input  logic [BYTE_W-1:0] head_data,
  input  logic              rsp_ready,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  output cell_ctl_t         cell_ctl,
  output logic [CNT_W-1:0]  count,
  output logic              rsp_valid,
  output rsp_item_t         rsp
);

  logic [CNT_W-1:0] xoff_level;
  logic [CNT_W-1:0] xon_level;
  logic             xoff;
  logic [CNT_W-1:0] count_next;
  logic             xoff_next;
  logic [CNT_W-1:0] count_dec;
  logic             push_req;
  logic             pop_req;
  logic             push_ok;
  logic             pop_ok;
  logic             full;
  logic             xoff_hit;
  logic             xon_hit;
  rsp_item_t        rsp_next;

  assign push_req  = accept && (req.opcode == OP_PUSH);
  assign pop_req   = accept && (req.opcode == OP_POP);
  assign full      = (count == CNT_W'(FIFO_DEPTH));
  assign push_ok   = push_req && !full;
  assign pop_ok    = pop_req && (count != '0);
  assign count_dec = count - CNT_W'(1);

  // The XOFF check looks at the count from before the push, even when the
  // byte is then dropped.
  assign xoff_hit = push_req && (count >= xoff_level) && !xoff;
  assign xon_hit  = pop_ok && (count_dec < xon_level) && xoff;

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count_dec;
    end
  end

  always_comb begin
    xoff_next = xoff;
    if (xoff_hit) begin
      xoff_next = 1'b1;
    end else if (xon_hit) begin
      xoff_next = 1'b0;
    end
  end

  always_comb begin
    rsp_next               = '0;
    rsp_next.data_out      = pop_ok ? head_data : '0;
    rsp_next.data_valid    = pop_ok;
    rsp_next.empty_flag    = pop_req && !pop_ok;
    rsp_next.overflow_flag = push_req && full;
    rsp_next.flow_send     = xoff_hit || xon_hit;
    rsp_next.flow_code     = xoff_hit ? FLOW_XOFF : FLOW_XON;
    rsp_next.fill_level    = count_next;
  end

  assign cell_ctl.push = push_ok;
  assign cell_ctl.pop  = pop_ok;
  assign cell_ctl.data = req.data_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      xoff      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      xoff  <= xoff_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xoff_level <= XOFF_LEVEL_RST;
      xon_level  <= XON_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XOFF_LEVEL: xoff_level <= cfg_data;
        REG_XON_LEVEL:  xon_level  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: tb/rx_fifo_flow_checker.sv
`timescale 1ns / 1ps
module rx_fifo_flow_checker import rxfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  req_item_t        req,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  rsp_item_t        rsp,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               results_seen,
  output int               xoff_seen,
  output int               xon_seen,
  output int               overflow_seen,
  output int               empty_seen
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int PRINT_CAP = 40;

  // Shadow copy of the FIFO and its flow control state.
  logic [BYTE_W-1:0] byte_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  int unsigned       fill;
  logic              xoff_on;
  logic [CNT_W-1:0]  upper_lim;
  logic [CNT_W-1:0]  lower_lim;

  rsp_item_t expected_q [$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    results_seen  = 0;
    xoff_seen     = 0;
    xon_seen      = 0;
    overflow_seen = 0;
    empty_seen    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("mismatch at result %0d: %s expected 0x%0h got 0x%0h",
               results_seen, what, want, got);
    end
  endtask

  function automatic rsp_item_t predict_fifo(input req_item_t it);
    rsp_item_t r;
    r = '0;
    if (opcode_t'(it.opcode) == OP_PUSH) begin
      // The XOFF decision looks at the count from before the push,
      // even when the byte is about to be dropped.
      if (fill >= upper_lim && !xoff_on) begin
        xoff_on     = 1'b1;
        r.flow_send = 1'b1;
        r.flow_code = FLOW_XOFF;
      end
      if (fill >= FIFO_DEPTH) begin
        r.overflow_flag = 1'b1;
      end else begin
        byte_mem[tail_ptr] = it.data_in;
        tail_ptr = tail_ptr + 1'b1;
        fill++;
      end
    end else if (fill == 0) begin
      r.empty_flag = 1'b1;
    end else begin
      r.data_out   = byte_mem[head_ptr];
      r.data_valid = 1'b1;
      head_ptr = head_ptr + 1'b1;
      fill--;
      if (fill < lower_lim && xoff_on) begin
        xoff_on     = 1'b0;
        r.flow_send = 1'b1;
        r.flow_code = FLOW_XON;
      end
    end
    r.fill_level = CNT_W'(fill);
    return r;
  endfunction

  task automatic check_result(input rsp_item_t got);
    rsp_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("item with nothing expected", '0, 32'(got));
      return;
    end
    want = expected_q.pop_front();
    results_seen++;
    if (want.flow_send && want.flow_code == FLOW_XOFF) xoff_seen++;
    if (want.flow_send && want.flow_code == FLOW_XON) xon_seen++;
    if (want.overflow_flag) overflow_seen++;
    if (want.empty_flag) empty_seen++;
    if (got.data_out !== want.data_out)
      report_mismatch("data_out", 32'(want.data_out), 32'(got.data_out));
    if (got.data_valid !== want.data_valid)
      report_mismatch("data_valid", 32'(want.data_valid), 32'(got.data_valid));
    if (got.empty_flag !== want.empty_flag)
      report_mismatch("empty_flag", 32'(want.empty_flag), 32'(got.empty_flag));
    if (got.overflow_flag !== want.overflow_flag)
      report_mismatch("overflow_flag", 32'(want.overflow_flag), 32'(got.overflow_flag));
    if (got.flow_send !== want.flow_send)
      report_mismatch("flow_send", 32'(want.flow_send), 32'(got.flow_send));
    if (got.flow_code !== want.flow_code)
      report_mismatch("flow_code", 32'(want.flow_code), 32'(got.flow_code));
    if (got.fill_level !== want.fill_level)
      report_mismatch("fill_level", 32'(want.fill_level), 32'(got.fill_level));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_ptr  = '0;
      tail_ptr  = '0;
      fill      = 0;
      xoff_on   = 1'b0;
      upper_lim = XOFF_LEVEL_RST;
      lower_lim = XON_LEVEL_RST;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_XOFF_LEVEL: upper_lim = cfg_data;
          REG_XON_LEVEL:  lower_lim = cfg_data;
          default: ;
        endcase
      end
      // The new expectation goes in first so that a result leaving at the
      // same edge still meets the oldest one at the front.
      if (req_valid && req_ready) expected_q.push_back(predict_fifo(req));
      if (rsp_valid && rsp_ready) check_result(rsp);
    end
    pending <= expected_q.size();
  end

endmodule

// File: tb/tb_rx_fifo_xon_xoff_flow_control.sv
`timescale 1ns / 1ps
module tb_rx_fifo_xon_xoff_flow_control;
  import rxfc_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 100000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_item_t        req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_item_t        rsp;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int results_seen;
  int xoff_seen;
  int xon_seen;
  int overflow_seen;
  int empty_seen;

  int items_sent  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int cycle_count = 0;
  bit hold        = 1'b0;

  logic [CNT_W-1:0] upper_set [PHASES] = '{6'd16, 6'd0, 6'd32, 6'd63, 6'd20, 6'd0};
  logic [CNT_W-1:0] lower_set [PHASES] = '{6'd8, 6'd32, 6'd0, 6'd63, 6'd10, 6'd0};

  always #1 clk = ~clk;

  rx_fifo_xon_xoff_flow_control dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rx_fifo_flow_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .xoff_seen     (xoff_seen),
    .xon_seen      (xon_seen),
    .overflow_seen (overflow_seen),
    .empty_seen    (empty_seen)
  );

  always @(negedge clk) begin
    rsp_ready <= !hold && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Called and returning at a falling edge; valid stays high so that a
  // following item can go out back to back.
  task automatic send_item(input opcode_t op, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    req.opcode   <= op;
    req.data_in  <= b;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_limit(input reg_index_t idx, input logic [CNT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_mode(input int idle, input int stall);
    @(posedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    @(negedge clk);
  endtask

  // Mostly fill and drain bursts with random bytes, so that the count sweeps
  // through both limits and into the full state; the rest is random mixes
  // and pops that may hit an empty FIFO.
  task automatic run_sequence;
    int kind;
    int push_pct;
    kind = $urandom_range(9);
    if (kind < 6) begin
      repeat ($urandom_range(1, 40)) send_item(OP_PUSH, BYTE_W'($urandom));
      repeat ($urandom_range(1, 40)) send_item(OP_POP, BYTE_W'($urandom));
    end else if (kind < 9) begin
      push_pct = $urandom_range(20, 80);
      repeat (16)
        send_item(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, BYTE_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) send_item(OP_POP, BYTE_W'($urandom));
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset limits: empty pop, extreme bytes, drain back to empty.
    send_item(OP_POP, 8'hFF);
    send_item(OP_PUSH, 8'h00);
    send_item(OP_PUSH, 8'hFF);
    send_item(OP_PUSH, 8'hA5);
    repeat (3) send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    drain();

    // An XOFF level of zero raises XOFF on the very first push.
    write_limit(REG_XOFF_LEVEL, 6'd0);
    write_limit(REG_XON_LEVEL, 6'd1);
    send_item(OP_PUSH, 8'h5A);
    send_item(OP_PUSH, 8'h3C);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    send_item(OP_POP, 8'h00);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) begin
        write_limit(REG_XOFF_LEVEL, CNT_W'($urandom_range(0, 63)));
        write_limit(REG_XON_LEVEL, CNT_W'($urandom_range(0, 63)));
      end else begin
        write_limit(REG_XOFF_LEVEL, upper_set[phase]);
        write_limit(REG_XON_LEVEL, lower_set[phase]);
      end
      case (phase % 4)
        0: set_mode(0, 0);
        1: set_mode(63, 0);
        2: set_mode(0, 63);
        default: set_mode(36, 36);
      endcase
      target = items_sent + PHASE_ITEMS;
      if (phase == 4) begin
        // The receiver holds off while the sender keeps offering pushes.
        fork
          begin
            @(posedge clk);
            hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold = 1'b0;
          end
          repeat (40) send_item(OP_PUSH, BYTE_W'($urandom));
        join
      end
      while (items_sent < target) run_sequence();
      drain();
    end

    $display("Sent %0d items: directed cases, then %0d phases of limits and idling",
             items_sent, PHASES);
    $display("Checked %0d results: %0d XOFF, %0d XON, %0d overflow, %0d empty pops",
             results_seen, xoff_seen, xon_seen, overflow_seen, empty_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/rxfc_pkg.sv
design/rxfc_cell.sv
design/rxfc_ctrl.sv
design/rx_fifo_xon_xoff_flow_control.sv
tb/rx_fifo_flow_checker.sv
tb/tb_rx_fifo_xon_xoff_flow_control.sv
